// ===== hdl/circular_deque_defines.svh =====
// ----------------------------------------------------------------------------
// circular_deque_defines
// assertion macros for the deque rtl
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CDQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque check failed");

// next-cycle implication, checked out of reset
`define CDQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

// ===== hdl/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// types, constants and ring pointer helpers for the circular deque
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IO_W       = 32;
  localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [2:0] {
    ACT_PUSH_REAR  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_REAR   = 3'd3,
    ACT_PEEK_FRONT = 3'd4,
    ACT_PEEK_REAR  = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]      action;
    logic [IO_W-1:0] push_value;
  } in_beat_t;

  typedef struct packed {
    logic [IO_W-1:0] read_value;
    logic [1:0]      status;
    logic            now_empty;
    logic            now_full;
  } out_beat_t;

  function automatic ptr_t ring_next(ptr_t p);
    ptr_t r;
    if (p == PTR_W'(DEPTH - 1)) r = '0;
    else r = p + PTR_W'(1);
    return r;
  endfunction

  function automatic ptr_t ring_prev(ptr_t p);
    ptr_t r;
    if (p == '0) r = PTR_W'(DEPTH - 1);
    else r = p - PTR_W'(1);
    return r;
  endfunction

endpackage

// ===== hdl/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque
// double-ended queue in a ring of slots held in one synchronous ram
// ----------------------------------------------------------------------------
// usage
// - command in: in_beat (action, push_value) is taken at a rising edge where
//   start is high and busy is low
// - actions: push rear, push front, pop front, pop rear, peek front, peek rear;
//   push on full or pop/peek on empty is refused with a status code and
//   leaves the deque untouched; unused action codes just report the flags
// - result out: out_beat is valid for exactly one cycle while out_strobe is
//   high, in the cycle after the command beat; the receiver cannot stall it
// - throughput: one command per cycle; every command makes at most one ram
//   access (write for a push, read for a pop or peek) at the accept edge,
//   and the ram's registered read data is what delays the result beat
// - busy stays low: no command ever has to wait
// - capacity is one less than the ring size, one slot always stays empty
// - reset (rst_n low, synchronous) empties the deque and drops any pending
//   result; ram contents are left as they are, never-written slots are
//   never read since only occupied slots are popped or peeked
// ----------------------------------------------------------------------------
`include "circular_deque_defines.svh"

module circular_deque (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  cdq_pkg::in_beat_t    in_beat,
  output logic                 out_strobe,
  output cdq_pkg::out_beat_t   out_beat
);

  // pointers: front sits on the empty slot ahead of the first element,
  // rear on the last element
  cdq_pkg::ptr_t front_r, front_nxt;
  cdq_pkg::ptr_t rear_r,  rear_nxt;

  // result pipeline stage
  logic                 out_strobe_r;
  logic [1:0]           status_r, status_nxt;
  logic                 rd_sel_r, rd_sel_nxt;
  logic                 empty_r, full_r;

  // ram port
  logic                           ram_we, ram_re;
  cdq_pkg::ptr_t                  ram_addr;
  logic [cdq_pkg::DATA_WIDTH-1:0] ram_rdata;

  logic accept;
  logic cur_empty, cur_full;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign cur_empty = (front_r == rear_r);
  assign cur_full  = (cdq_pkg::ring_next(rear_r) == front_r);

  // decode the command into at most one ram access and the pointer moves
  always_comb begin
    front_nxt  = front_r;
    rear_nxt   = rear_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = rear_r;
    status_nxt = cdq_pkg::ST_OK;
    rd_sel_nxt = 1'b0;
    if (accept) begin
      case (in_beat.action)
        cdq_pkg::ACT_PUSH_REAR: begin
          if (cur_full) begin
            status_nxt = cdq_pkg::ST_FULL;
          end else begin
            rear_nxt = cdq_pkg::ring_next(rear_r);
            ram_addr = cdq_pkg::ring_next(rear_r);
            ram_we   = 1'b1;
          end
        end
        cdq_pkg::ACT_PUSH_FRONT: begin
          if (cur_full) begin
            status_nxt = cdq_pkg::ST_FULL;
          end else begin
            // write into the spare slot, then step front back past it
            ram_addr  = front_r;
            ram_we    = 1'b1;
            front_nxt = cdq_pkg::ring_prev(front_r);
          end
        end
        cdq_pkg::ACT_POP_FRONT: begin
          if (cur_empty) begin
            status_nxt = cdq_pkg::ST_EMPTY;
          end else begin
            front_nxt  = cdq_pkg::ring_next(front_r);
            ram_addr   = cdq_pkg::ring_next(front_r);
            ram_re     = 1'b1;
            rd_sel_nxt = 1'b1;
          end
        end
        cdq_pkg::ACT_POP_REAR: begin
          if (cur_empty) begin
            status_nxt = cdq_pkg::ST_EMPTY;
          end else begin
            ram_addr   = rear_r;
            ram_re     = 1'b1;
            rd_sel_nxt = 1'b1;
            rear_nxt   = cdq_pkg::ring_prev(rear_r);
          end
        end
        cdq_pkg::ACT_PEEK_FRONT: begin
          if (cur_empty) begin
            status_nxt = cdq_pkg::ST_EMPTY;
          end else begin
            ram_addr   = cdq_pkg::ring_next(front_r);
            ram_re     = 1'b1;
            rd_sel_nxt = 1'b1;
          end
        end
        cdq_pkg::ACT_PEEK_REAR: begin
          if (cur_empty) begin
            status_nxt = cdq_pkg::ST_EMPTY;
          end else begin
            ram_addr   = rear_r;
            ram_re     = 1'b1;
            rd_sel_nxt = 1'b1;
          end
        end
        default: begin
          // unused codes: no access, flags only
        end
      endcase
    end
  end

  cdq_ram #(
    .DEPTH (cdq_pkg::DEPTH),
    .WIDTH (cdq_pkg::DATA_WIDTH),
    .AW    (cdq_pkg::PTR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (in_beat.push_value[cdq_pkg::DATA_WIDTH-1:0]),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r      <= '0;
      rear_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      front_r      <= front_nxt;
      rear_r       <= rear_nxt;
      out_strobe_r <= accept;
    end
  end

  // result payload, flags taken from the pointers after the step
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    rd_sel_r <= rd_sel_nxt;
    empty_r  <= (front_nxt == rear_nxt);
    full_r   <= (cdq_pkg::ring_next(rear_nxt) == front_nxt);
  end

  assign out_strobe          = out_strobe_r;
  assign out_beat.read_value = rd_sel_r ? cdq_pkg::IO_W'(ram_rdata) : '0;
  assign out_beat.status     = status_r;
  assign out_beat.now_empty  = empty_r;
  assign out_beat.now_full   = full_r;

  // every command beat yields exactly one result beat, in the next cycle
  `CDQ_ASSERT_NEXT(a_result_follows, accept, out_strobe)
  `CDQ_ASSERT_NEXT(a_no_spurious_result, !accept, !out_strobe)
  // a ring of two or more slots is never both empty and full
  `CDQ_ASSERT_NOW(a_flags_exclusive, out_strobe, !(out_beat.now_empty && out_beat.now_full))
  // a refused pop leaves both pointers where they were
  `CDQ_ASSERT_NEXT(a_refused_pop_holds,
    accept && cur_empty && (in_beat.action == cdq_pkg::ACT_POP_FRONT ||
    in_beat.action == cdq_pkg::ACT_POP_REAR), $stable(front_r) && $stable(rear_r))
  // a refused push is reported as full
  `CDQ_ASSERT_NEXT(a_refused_push_status,
    accept && cur_full && (in_beat.action == cdq_pkg::ACT_PUSH_REAR ||
    in_beat.action == cdq_pkg::ACT_PUSH_FRONT), out_beat.status == cdq_pkg::ST_FULL)

endmodule

// ===== hdl/cdq_ram.sv =====
// ----------------------------------------------------------------------------
// cdq_ram
// single-port synchronous ram, registered read data
// ----------------------------------------------------------------------------
module cdq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule
